[src/dqts_pkg.sv]
// Shared types and codes of the delta-queue task scheduler.
package dqts_pkg;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_ADD      = 2'd1,
    OP_DELETE   = 2'd2,
    OP_DISPATCH = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_DUE  = 2'd1,
    ST_FULL     = 2'd2,
    ST_NO_ID    = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] delay_ticks;
    logic [31:0] period_ticks;
    logic [15:0] target_id;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] task_id;
    logic [4:0]  task_count;
  } res_t;

  typedef struct packed {
    logic [31:0] delta;
    logic [31:0] period;
    logic [15:0] ident;
  } entry_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_TICK,
    CMD_INS_EV,
    CMD_SHF_EV,
    CMD_DEL_EV,
    CMD_CMP_EV,
    CMD_DSP_EV
  } dp_cmd_e;

  typedef struct packed {
    logic full;
    logic ins_walk;
    logic ins_tail;
    logic shf_last;
    logic del_end;
    logic del_hit;
    logic cmp_end;
    logic reinsert;
    logic dsp_due;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK_RD,
    S_TICK_EV,
    S_INS_RD,
    S_INS_EV,
    S_SHF_RD,
    S_SHF_EV,
    S_DEL_RD,
    S_DEL_EV,
    S_CMP_RD,
    S_CMP_EV,
    S_DSP_RD,
    S_DSP_EV,
    S_DONE
  } state_e;

endpackage

[src/dqts_ctrl.sv]
// Sequencer of the task scheduler: walks the table one entry per read/evaluate pair.
module dqts_ctrl import dqts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] opcode_i,
  input  dp_stat_t   stat_i,
  output dp_cmd_e    cmd_o,
  output logic       busy_o,
  output logic       done_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (op_e'(opcode_i))
            OP_TICK:     state_d = S_TICK_RD;
            OP_ADD:      state_d = stat_i.full ? S_DONE : S_INS_RD;
            OP_DELETE:   state_d = S_DEL_RD;
            OP_DISPATCH: state_d = S_DSP_RD;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_TICK_RD: state_d = S_TICK_EV;
      S_TICK_EV: state_d = S_DONE;
      S_INS_RD:  state_d = S_INS_EV;
      S_INS_EV: begin
        priority if (stat_i.ins_walk) state_d = S_INS_RD;
        else if (stat_i.ins_tail)     state_d = S_DONE;
        else                          state_d = S_SHF_RD;
      end
      S_SHF_RD: state_d = S_SHF_EV;
      S_SHF_EV: state_d = stat_i.shf_last ? S_DONE : S_SHF_RD;
      S_DEL_RD: state_d = S_DEL_EV;
      S_DEL_EV: begin
        priority if (stat_i.del_end) state_d = S_DONE;
        else if (stat_i.del_hit)     state_d = S_CMP_RD;
        else                         state_d = S_DEL_RD;
      end
      S_CMP_RD: state_d = S_CMP_EV;
      S_CMP_EV: begin
        priority if (!stat_i.cmp_end) state_d = S_CMP_RD;
        else if (stat_i.reinsert)     state_d = S_INS_RD;
        else                          state_d = S_DONE;
      end
      S_DSP_RD: state_d = S_DSP_EV;
      S_DSP_EV: state_d = stat_i.dsp_due ? S_CMP_RD : S_DONE;
      S_DONE:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = CMD_NONE;
    busy_o = 1'b1;
    done_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) cmd_o = CMD_ACCEPT;
      end
      S_TICK_EV: cmd_o = CMD_TICK;
      S_INS_EV:  cmd_o = CMD_INS_EV;
      S_SHF_EV:  cmd_o = CMD_SHF_EV;
      S_DEL_EV:  cmd_o = CMD_DEL_EV;
      S_CMP_EV:  cmd_o = CMD_CMP_EV;
      S_DSP_EV:  cmd_o = CMD_DSP_EV;
      S_DONE:    done_o = 1'b1;
      default:   cmd_o = CMD_NONE;
    endcase
  end

endmodule

[src/dqts_dpath.sv]
// Datapath of the task scheduler: task table memory, counters and the walking registers.
module dqts_dpath import dqts_pkg::*; #(
  parameter int MaxTasks = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  req_t     req_i,
  input  dp_cmd_e  cmd_i,
  output dp_stat_t stat_o,
  output res_t     res_o
);

  localparam int AW = $clog2(MaxTasks);
  localparam int CW = $clog2(MaxTasks + 1);

  entry_t mem_q [MaxTasks];
  entry_t rd_q;

  logic [CW-1:0] count_q, count_d;
  logic [31:0]   pending_q, pending_d;
  logic [15:0]   next_id_q, next_id_d;

  logic [CW-1:0] idx_q, idx_d, idx_m1;
  logic [31:0]   w_delay_q, w_delay_d, w_period_q, w_period_d;
  logic [15:0]   w_id_q, w_id_d, target_q, target_d;
  entry_t        carry_q, carry_d;
  logic          first_q, first_d;
  logic [1:0]    op_q, op_d, res_status_q, res_status_d;
  logic [15:0]   res_id_q, res_id_d;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic [31:0]   pend_inc;
  logic [32:0]   sum;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    rd_q <= mem_q[idx_d[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      pending_q <= '0;
      next_id_q <= 16'd1;
    end else begin
      count_q   <= count_d;
      pending_q <= pending_d;
      next_id_q <= next_id_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    w_delay_q    <= w_delay_d;
    w_period_q   <= w_period_d;
    w_id_q       <= w_id_d;
    target_q     <= target_d;
    carry_q      <= carry_d;
    first_q      <= first_d;
    op_q         <= op_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
  end

  always_comb begin
    stat_o.full     = (count_q == CW'(MaxTasks));
    stat_o.ins_walk = (idx_q < count_q) && (rd_q.delta <= w_delay_q);
    stat_o.ins_tail = (idx_q >= count_q);
    stat_o.shf_last = (idx_q == count_q);
    stat_o.del_end  = (idx_q >= count_q);
    stat_o.del_hit  = (rd_q.ident == target_q);
    stat_o.cmp_end  = (idx_q >= count_q);
    stat_o.reinsert = (op_q == OP_DISPATCH) && (w_period_q != '0);
    stat_o.dsp_due  = (count_q != '0) && (rd_q.delta == '0);
  end

  always_comb begin
    count_d      = count_q;
    pending_d    = pending_q;
    next_id_d    = next_id_q;
    idx_d        = idx_q;
    w_delay_d    = w_delay_q;
    w_period_d   = w_period_q;
    w_id_d       = w_id_q;
    target_d     = target_q;
    carry_d      = carry_q;
    first_d      = first_q;
    op_d         = op_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    idx_m1       = idx_q - CW'(1);
    wr_en        = 1'b0;
    wr_addr      = idx_q[AW-1:0];
    wr_data      = rd_q;
    pend_inc     = (pending_q == 32'hFFFF_FFFF) ? pending_q : pending_q + 32'd1;
    sum          = {1'b0, rd_q.delta} + {1'b0, carry_q.delta};
    unique case (cmd_i)
      CMD_NONE: ;
      CMD_ACCEPT: begin
        op_d         = req_i.opcode;
        w_delay_d    = req_i.delay_ticks;
        w_period_d   = req_i.period_ticks;
        target_d     = req_i.target_id;
        idx_d        = '0;
        res_status_d = ST_OK;
        res_id_d     = '0;
        if (req_i.opcode == OP_ADD) begin
          if (stat_o.full) begin
            res_status_d = ST_FULL;
          end else begin
            w_id_d    = next_id_q;
            res_id_d  = next_id_q;
            next_id_d = (next_id_q == 16'hFFFF) ? 16'd1 : next_id_q + 16'd1;
          end
        end
      end
      CMD_TICK: begin
        if (count_q == '0) begin
          pending_d = '0;
        end else if (rd_q.delta == '0) begin
          pending_d = pend_inc;
        end else if (rd_q.delta >= pend_inc) begin
          wr_en         = 1'b1;
          wr_data.delta = rd_q.delta - pend_inc;
          pending_d     = '0;
        end else begin
          wr_en         = 1'b1;
          wr_data.delta = '0;
          pending_d     = pend_inc - rd_q.delta;
        end
      end
      CMD_INS_EV: begin
        if (stat_o.ins_walk) begin
          w_delay_d = w_delay_q - rd_q.delta;
          idx_d     = idx_q + CW'(1);
        end else begin
          wr_en         = 1'b1;
          wr_data       = '{delta: w_delay_q, period: w_period_q, ident: w_id_q};
          carry_d       = rd_q;
          carry_d.delta = rd_q.delta - w_delay_q;
          if (stat_o.ins_tail) count_d = count_q + CW'(1);
          else                 idx_d   = idx_q + CW'(1);
        end
      end
      CMD_SHF_EV: begin
        wr_en   = 1'b1;
        wr_data = carry_q;
        carry_d = rd_q;
        if (stat_o.shf_last) count_d = count_q + CW'(1);
        else                 idx_d   = idx_q + CW'(1);
      end
      CMD_DEL_EV: begin
        if (stat_o.del_end) begin
          res_status_d = ST_NO_ID;
        end else begin
          if (stat_o.del_hit) begin
            carry_d.delta = rd_q.delta;
            first_d       = 1'b1;
          end
          idx_d = idx_q + CW'(1);
        end
      end
      CMD_CMP_EV: begin
        if (stat_o.cmp_end) begin
          count_d = count_q - CW'(1);
          idx_d   = '0;
        end else begin
          wr_en   = 1'b1;
          wr_addr = idx_m1[AW-1:0];
          if (first_q) wr_data.delta = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          first_d = 1'b0;
          idx_d   = idx_q + CW'(1);
        end
      end
      CMD_DSP_EV: begin
        if (!stat_o.dsp_due) begin
          res_status_d = ST_NOT_DUE;
        end else begin
          res_id_d   = rd_q.ident;
          w_delay_d  = rd_q.period;
          w_period_d = rd_q.period;
          w_id_d     = rd_q.ident;
          idx_d      = CW'(1);
          first_d    = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign res_o.status     = res_status_q;
  assign res_o.task_id    = res_id_q;
  assign res_o.task_count = 5'(count_q);

endmodule

[src/delta_queue_task_scheduler_unit.sv]
// Top level of the delta-queue task scheduler.
//
// A request is taken on req_i when start_i is high and busy_o is low. The
// opcode selects tick, add, delete or dispatch. Every request produces one
// result on res_o, shown for exactly one cycle while done_o is high; the
// receiver cannot hold it off, so it must take it in that cycle.
// The table lives in a single-port-write, registered-read memory, and each
// table entry visited takes a read step and then an evaluate step. A tick
// visits only the head entry. An add walks to its slot and then shifts
// the entries behind it. A delete searches and compacts. A dispatch pops
// the head with a compaction and then, for a periodic task, runs a full
// insert. A refused add goes straight to the result.
// busy_o goes high in the cycle after the accept and stays high through the
// done_o cycle, so one request is in flight at a time.
// Reset empties the table, clears the piled-up tick count and restarts ids
// at one; table contents are not cleared since only held entries are read.
module delta_queue_task_scheduler_unit import dqts_pkg::*; #(
  parameter int MaxTasks = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic done_o,
  output res_t res_o
);

  dp_cmd_e  cmd;
  dp_stat_t stat;

  // The sequencer decides which table step runs each cycle.
  dqts_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .opcode_i(req_i.opcode),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // The datapath holds the table and executes the commanded step.
  dqts_dpath #(
    .MaxTasks(MaxTasks)
  ) u_dpath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i),
    .cmd_i (cmd),
    .stat_o(stat),
    .res_o (res_o)
  );

endmodule

[src/dqts_checker.sv]
// Port-level checks of the task scheduler and their attachment to the top level.
module dqts_checker import dqts_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input res_t res_o
);

  // A result only appears while a request is in flight.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result strobe outside a request");

  // An accepted request makes the block busy.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("request accepted but not busy");

  // After a result the block is ready again.
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o && !done_o) else $error("block not freed after result");

  // A refused add never hands out an id.
  a_full_noid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status == ST_FULL) |-> res_o.task_id == '0)
    else $error("id given on a full table");

endmodule

bind delta_queue_task_scheduler_unit dqts_checker u_dqts_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start_i(start_i),
  .busy_o (busy_o),
  .done_o (done_o),
  .res_o  (res_o)
);
